// File: sv/kscm_pkg.sv
package kscm_pkg;

    // Field widths fixed by the item format
    localparam int KEY_W    = 8;
    localparam int SEQ_W    = 64;
    localparam int LEN_W    = 4;
    localparam int CODE_W   = 8;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 16;

    // Width used to compare counts and slot numbers against the table depth
    localparam int EXT_W = 11;

    // Defaults for the top level parameters
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int MAX_SEQ_DEF     = 8;

    // Input kinds carried in s_tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_KEY   = 1'b1;

    // Code reported for an unrecognised sequence
    localparam logic [CODE_W-1:0] CODE_NONE = '0;

    // One table entry as held in the memory
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic [SEQ_W-1:0]  bytes;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    // Mask covering the low n bytes of a sequence word
    function automatic logic [SEQ_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [SEQ_W-1:0] m;
        m = '0;
        for (int b = 0; b < SEQ_W / 8; b++) begin
            if (int'(n) > b) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// File: sv/key_sequence_command_matcher.sv
// Key sequence matcher. Write items (s_tuser = 0) load one table slot; slots at or above
// TABLE_DEPTH are ignored. Key items (s_tuser = 1) append a byte to the prefix buffer and
// start a scan of the first min(entry_count, TABLE_DEPTH) slots in order.
// The table sits in one single-port synchronous memory, read one entry per cycle. The scan
// stops at the first entry whose leading bytes equal the buffer; each entry read is registered
// before the compare, and the result is then loaded into the output register once it is free.
// A new item is taken only once the previous key has finished; a finished result may still
// wait in the output register meanwhile. The table has no reset: entry_count must not cover
// slots that were never written. Writes and scans never overlap, so no forwarding is needed.
module key_sequence_command_matcher #(
    parameter int TABLE_DEPTH = kscm_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_SEQ     = kscm_pkg::MAX_SEQ_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration: entry_count
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kscm_pkg::CNT_W-1:0]    cfg_data,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // entry_index[5:0], entry_bytes[69:6], entry_length[73:70], entry_code[81:74],
    // key_byte[89:82], zero[95:90]
    input  logic [kscm_pkg::S_DATA_W-1:0] s_tdata,
    // cmd[0]
    input  logic                          s_tuser,
    // Output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // command_code[7:0], keys_used[11:8], zero[15:12]
    output logic [kscm_pkg::M_DATA_W-1:0] m_tdata,
    // recognized[0]
    output logic                          m_tuser
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Input field unpacking
    logic [kscm_pkg::IDX_W-1:0]  in_index;
    logic [kscm_pkg::SEQ_W-1:0]  in_bytes;
    logic [kscm_pkg::LEN_W-1:0]  in_len;
    logic [kscm_pkg::CODE_W-1:0] in_code;
    logic [kscm_pkg::KEY_W-1:0]  in_key;

    assign in_index = s_tdata[5:0];
    assign in_bytes = s_tdata[69:6];
    assign in_len   = s_tdata[73:70];
    assign in_code  = s_tdata[81:74];
    assign in_key   = s_tdata[89:82];

    // Control and payload registers
    kscm_pkg::state_t             state_reg, state_next;
    logic [kscm_pkg::CNT_W-1:0]   entry_count_reg;
    logic [kscm_pkg::SEQ_W-1:0]   buf_reg, buf_next;
    logic [kscm_pkg::LEN_W-1:0]   prefix_count_reg, prefix_count_next;
    logic [CW-1:0]                rd_addr_reg, rd_addr_next;
    logic                         rd_pend_reg, rd_pend_next;
    logic                         res_rec_reg, res_rec_next;
    logic [kscm_pkg::CODE_W-1:0]  res_code_reg, res_code_next;
    logic [kscm_pkg::LEN_W-1:0]   res_used_reg, res_used_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic                         m_rec_reg, m_rec_next;
    logic [kscm_pkg::CODE_W-1:0]  m_code_reg, m_code_next;
    logic [kscm_pkg::LEN_W-1:0]   m_used_reg, m_used_next;

    // Table memory
    kscm_pkg::entry_t             mem [TABLE_DEPTH];
    kscm_pkg::entry_t             rd_data_reg;
    logic                         rd_en;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [kscm_pkg::EXT_W-1:0]   idx_ext;

    // Handshakes
    logic in_xfer;
    logic out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == kscm_pkg::ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Active slot count, saturated at the table depth
    logic [CW-1:0] act_cnt;

    always_comb
    begin
        if (kscm_pkg::EXT_W'(entry_count_reg) > kscm_pkg::EXT_W'(TABLE_DEPTH)) begin
            act_cnt = CW'(TABLE_DEPTH);
        end else begin
            act_cnt = CW'(entry_count_reg);
        end
    end

    // Entry count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            entry_count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            entry_count_reg <= cfg_data;
        end
    end

    // Table write on a write item to a slot in range
    assign idx_ext = kscm_pkg::EXT_W'(in_index);
    assign wr_en   = in_xfer && (s_tuser == kscm_pkg::CMD_WRITE)
                     && (idx_ext < kscm_pkg::EXT_W'(TABLE_DEPTH));
    assign wr_addr = idx_ext[AW-1:0];

    // Scan reads one slot per cycle while slots remain
    assign rd_en = (state_reg == kscm_pkg::ST_SCAN) && (rd_addr_reg < act_cnt);

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= '{code: in_code, len: in_len, bytes: in_bytes};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr_reg[AW-1:0]];
        end
    end

    // Prefix append for an incoming key
    logic [kscm_pkg::LEN_W-1:0] pc_base;
    logic [kscm_pkg::LEN_W-1:0] pc_new;
    logic [kscm_pkg::SEQ_W-1:0] buf_app;

    always_comb
    begin
        pc_base = (prefix_count_reg >= kscm_pkg::LEN_W'(MAX_SEQ)) ? '0 : prefix_count_reg;
        pc_new  = pc_base + kscm_pkg::LEN_W'(1);
        buf_app = (buf_reg & kscm_pkg::byte_mask(pc_base))
                  | (kscm_pkg::SEQ_W'(in_key) << {pc_base[2:0], 3'b000});
    end

    // Compare of the entry read in the previous cycle
    logic [kscm_pkg::SEQ_W-1:0] cmp_mask;
    logic                       eval;
    logic                       hit;
    logic                       last;

    always_comb
    begin
        cmp_mask = kscm_pkg::byte_mask(prefix_count_reg);
        eval     = (state_reg == kscm_pkg::ST_SCAN) && rd_pend_reg;
        hit      = eval && (rd_data_reg.len != '0)
                   && (rd_data_reg.len >= prefix_count_reg)
                   && (((rd_data_reg.bytes ^ buf_reg) & cmp_mask) == '0);
        last     = eval && (rd_addr_reg == act_cnt);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kscm_pkg::ST_IDLE:
            begin
                if (in_xfer && (s_tuser == kscm_pkg::CMD_KEY)) begin
                    state_next = (act_cnt == '0) ? kscm_pkg::ST_FIN : kscm_pkg::ST_SCAN;
                end
            end
            kscm_pkg::ST_SCAN:
            begin
                if (hit) begin
                    if ((rd_data_reg.len == prefix_count_reg)
                        || (prefix_count_reg >= kscm_pkg::LEN_W'(MAX_SEQ))) begin
                        state_next = kscm_pkg::ST_FIN;
                    end else begin
                        state_next = kscm_pkg::ST_IDLE;
                    end
                end else if (last) begin
                    state_next = kscm_pkg::ST_FIN;
                end
            end
            kscm_pkg::ST_FIN:
            begin
                if (out_free) begin
                    state_next = kscm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kscm_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output register
    always_comb
    begin
        buf_next          = buf_reg;
        prefix_count_next = prefix_count_reg;
        rd_addr_next      = rd_addr_reg;
        rd_pend_next      = 1'b0;
        res_rec_next      = res_rec_reg;
        res_code_next     = res_code_reg;
        res_used_next     = res_used_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_rec_next        = m_rec_reg;
        m_code_next       = m_code_reg;
        m_used_next       = m_used_reg;

        case (state_reg)
            kscm_pkg::ST_IDLE:
            begin
                if (in_xfer && (s_tuser == kscm_pkg::CMD_KEY)) begin
                    rd_addr_next = '0;
                    if (act_cnt == '0) begin
                        // Empty table: unrecognised straight away
                        res_rec_next      = 1'b0;
                        res_code_next     = kscm_pkg::CODE_NONE;
                        res_used_next     = pc_new;
                        buf_next          = '0;
                        prefix_count_next = '0;
                    end else begin
                        buf_next          = buf_app;
                        prefix_count_next = pc_new;
                    end
                end
            end
            kscm_pkg::ST_SCAN:
            begin
                if (rd_en) begin
                    rd_addr_next = rd_addr_reg + CW'(1);
                    rd_pend_next = 1'b1;
                end
                res_used_next = prefix_count_reg;
                if (hit) begin
                    rd_pend_next = 1'b0;
                    if (rd_data_reg.len == prefix_count_reg) begin
                        res_rec_next      = 1'b1;
                        res_code_next     = rd_data_reg.code;
                        buf_next          = '0;
                        prefix_count_next = '0;
                    end else if (prefix_count_reg >= kscm_pkg::LEN_W'(MAX_SEQ)) begin
                        // Entry longer than the buffer can ever hold
                        res_rec_next      = 1'b0;
                        res_code_next     = kscm_pkg::CODE_NONE;
                        buf_next          = '0;
                        prefix_count_next = '0;
                    end
                end else if (last) begin
                    res_rec_next      = 1'b0;
                    res_code_next     = kscm_pkg::CODE_NONE;
                    buf_next          = '0;
                    prefix_count_next = '0;
                end
            end
            kscm_pkg::ST_FIN:
            begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_rec_next    = res_rec_reg;
                    m_code_next   = res_code_reg;
                    m_used_next   = res_used_reg;
                end
            end
            default:
            begin
                rd_pend_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= kscm_pkg::ST_IDLE;
            buf_reg          <= '0;
            prefix_count_reg <= '0;
            rd_addr_reg      <= '0;
            rd_pend_reg      <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            buf_reg          <= buf_next;
            prefix_count_reg <= prefix_count_next;
            rd_addr_reg      <= rd_addr_next;
            rd_pend_reg      <= rd_pend_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_rec_reg  <= res_rec_next;
        res_code_reg <= res_code_next;
        res_used_reg <= res_used_next;
        m_rec_reg    <= m_rec_next;
        m_code_reg   <= m_code_next;
        m_used_reg   <= m_used_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_rec_reg;
    assign m_tdata  = {{(kscm_pkg::M_DATA_W - kscm_pkg::CODE_W - kscm_pkg::LEN_W){1'b0}},
                       m_used_reg, m_code_reg};

    // Checks
    a_prefix_short: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kscm_pkg::ST_IDLE) |-> (prefix_count_reg < kscm_pkg::LEN_W'(MAX_SEQ)))
        else $error("prefix count not below sequence limit while idle");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kscm_pkg::ST_SCAN) |-> (rd_addr_reg <= act_cnt))
        else $error("scan address ran past the active slots");

    a_result_sane: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ((m_used_reg != '0)
                                 && (m_rec_reg || (m_code_reg == kscm_pkg::CODE_NONE))))
        else $error("malformed result loaded");

endmodule

// File: dv/key_match_checker.sv
module key_match_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [kscm_pkg::CNT_W-1:0]    cfg_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // entry_index, entry_bytes, entry_length, entry_code, key_byte, zero
    input  logic [kscm_pkg::S_DATA_W-1:0] s_tdata,
    // cmd
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // command_code, keys_used, zero
    input  logic [kscm_pkg::M_DATA_W-1:0] m_tdata,
    // recognized
    input  logic                          m_tuser,
    output int                            fails,
    output int                            pending
);

    localparam int DEPTH    = 64;
    localparam int MAX_KEYS = 8;

    // Field offsets inside s_tdata
    localparam int OFS_BYTES = kscm_pkg::IDX_W;
    localparam int OFS_LEN   = OFS_BYTES + kscm_pkg::SEQ_W;
    localparam int OFS_CODE  = OFS_LEN + kscm_pkg::LEN_W;
    localparam int OFS_KEY   = OFS_CODE + kscm_pkg::CODE_W;

    typedef struct packed {
        logic                        recognized;
        logic [kscm_pkg::CODE_W-1:0] code;
        logic [kscm_pkg::LEN_W-1:0]  keys;
    } report_t;

    // Own copy of the table, prefix buffer and active count
    logic [kscm_pkg::SEQ_W-1:0]  tab_seq  [DEPTH];
    logic [kscm_pkg::LEN_W-1:0]  tab_len  [DEPTH];
    logic [kscm_pkg::CODE_W-1:0] tab_code [DEPTH];
    logic [kscm_pkg::SEQ_W-1:0]  typed_bytes;
    int                          typed_count;
    logic [kscm_pkg::CNT_W-1:0]  scan_limit;
    report_t                     expected_reports [$];

    function automatic logic [kscm_pkg::SEQ_W-1:0] low_bytes(input int n);
        if (n >= MAX_KEYS)
            return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // Append one key to the prefix; queue a report if the scan settles the sequence
    function automatic void match_key(input logic [kscm_pkg::KEY_W-1:0] key);
        logic [kscm_pkg::SEQ_W-1:0] mask;
        int                         active;
        int                         hit;
        report_t                    rep;
        if (typed_count >= MAX_KEYS)
            typed_count = 0;
        typed_bytes = (typed_bytes & low_bytes(typed_count))
                    | (kscm_pkg::SEQ_W'(key) << (8 * typed_count));
        typed_count++;
        mask   = low_bytes(typed_count);
        active = (scan_limit > DEPTH) ? DEPTH : int'(scan_limit);
        hit    = -1;
        // first entry whose leading bytes agree wins, even if only a prefix
        for (int k = 0; k < active && hit < 0; k++)
        begin
            if (tab_len[k] != 0 && int'(tab_len[k]) >= typed_count
                && (tab_seq[k] & mask) == (typed_bytes & mask))
                hit = k;
        end
        if (hit < 0)
            rep = '{1'b0, kscm_pkg::CODE_NONE, kscm_pkg::LEN_W'(typed_count)};
        else if (int'(tab_len[hit]) == typed_count)
            rep = '{1'b1, tab_code[hit], kscm_pkg::LEN_W'(typed_count)};
        else if (typed_count >= MAX_KEYS)
            rep = '{1'b0, kscm_pkg::CODE_NONE, kscm_pkg::LEN_W'(typed_count)};
        else
            return;
        expected_reports.push_back(rep);
        typed_bytes = '0;
        typed_count = 0;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            typed_bytes = '0;
            typed_count = 0;
            scan_limit  = '0;
            expected_reports.delete();
            fails   = 0;
            pending = 0;
        end
        else
        begin
            // Result transfer against the oldest expectation
            if (m_tvalid && m_tready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual rec %0d code %0d keys %0d",
                             $time, m_tuser, m_tdata[kscm_pkg::CODE_W-1:0],
                             m_tdata[kscm_pkg::CODE_W +: kscm_pkg::LEN_W]);
                    fails++;
                end
                else
                begin
                    compare_field("recognized", expected_reports[0].recognized, m_tuser);
                    compare_field("command_code", expected_reports[0].code,
                                  m_tdata[kscm_pkg::CODE_W-1:0]);
                    compare_field("keys_used", expected_reports[0].keys,
                                  m_tdata[kscm_pkg::CODE_W +: kscm_pkg::LEN_W]);
                    void'(expected_reports.pop_front());
                end
            end
            if (cfg_valid && cfg_ready)
                scan_limit = cfg_data;
            // Input transfer: table write or keystroke
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == kscm_pkg::CMD_WRITE)
                begin
                    tab_seq[s_tdata[kscm_pkg::IDX_W-1:0]]  = s_tdata[OFS_BYTES +: kscm_pkg::SEQ_W];
                    tab_len[s_tdata[kscm_pkg::IDX_W-1:0]]  = s_tdata[OFS_LEN +: kscm_pkg::LEN_W];
                    tab_code[s_tdata[kscm_pkg::IDX_W-1:0]] = s_tdata[OFS_CODE +: kscm_pkg::CODE_W];
                end
                else
                    match_key(s_tdata[OFS_KEY +: kscm_pkg::KEY_W]);
            end
            pending = expected_reports.size();
        end
    end

endmodule

// File: dv/tb.sv
module tb;

    localparam int TABLE_SLOTS    = 64;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int ITEM_TARGET    = 750;
    localparam int CALM_FROM      = 650;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [kscm_pkg::CNT_W-1:0]    cfg_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [kscm_pkg::S_DATA_W-1:0] s_tdata;
    logic                          s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [kscm_pkg::M_DATA_W-1:0] m_tdata;
    logic                          m_tuser;
    int                            fails;
    int                            pending;

    // Copy of the table used only to aim keystrokes at stored sequences
    logic [kscm_pkg::SEQ_W-1:0]    aim_seq [TABLE_SLOTS];
    logic [kscm_pkg::LEN_W-1:0]    aim_len [TABLE_SLOTS];
    logic [kscm_pkg::CNT_W-1:0]    live_count;
    int                            items_sent  = 0;
    int                            idle_cycles = 0;
    int                            send_quiet  = 0;
    bit                            calm        = 1'b0;
    bit                            long_hold   = 1'b0;

    key_sequence_command_matcher u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    key_match_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .fails     (fails),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Result side: random stalls, quiet stretches and one long hold-off
    initial
    begin
        int stall_left;
        int quiet_left;
        stall_left = 0;
        quiet_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                long_hold  = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !calm)
            begin
                if (quiet_left > 0)
                    quiet_left--;
                else if ($urandom_range(0, 31) == 0)
                    quiet_left = $urandom_range(20, 120);
                else if ($urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 17);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // One transfer on the input side, with an occasional gap in front
    task automatic send_item(input logic kind, input logic [kscm_pkg::S_DATA_W-1:0] data);
        int gap;
        gap = 0;
        if (!calm)
        begin
            if (send_quiet > 0)
                send_quiet--;
            else if ($urandom_range(0, 15) == 0)
                send_quiet = $urandom_range(10, 60);
            else if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 17);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    // Unused fields carry junk so that the block is seen to ignore them
    task automatic write_entry(input int slot, input logic [kscm_pkg::SEQ_W-1:0] bytes,
                               input logic [kscm_pkg::LEN_W-1:0] len,
                               input logic [kscm_pkg::CODE_W-1:0] code);
        aim_seq[slot] = bytes;
        aim_len[slot] = len;
        send_item(kscm_pkg::CMD_WRITE,
                  {6'b0, 8'($urandom), code, len, bytes, kscm_pkg::IDX_W'(slot)});
    endtask

    task automatic press(input logic [kscm_pkg::KEY_W-1:0] key);
        send_item(kscm_pkg::CMD_KEY, {6'b0, key, 8'($urandom), 4'($urandom),
                                      {$urandom, $urandom}, 6'($urandom)});
    endtask

    // Escape-like bytes so that stored sequences share prefixes
    function automatic logic [7:0] seq_byte();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'h1b;
            4, 5:       return 8'h5b;
            6, 7:       return 8'h41 + 8'($urandom_range(0, 3));
            default:    return 8'($urandom);
        endcase
    endfunction

    task automatic write_random(input int slot);
        logic [kscm_pkg::SEQ_W-1:0] bytes;
        logic [kscm_pkg::LEN_W-1:0] len;
        bytes = {$urandom, $urandom};
        case ($urandom_range(0, 19))
            0:       len = '0;
            1:       len = kscm_pkg::LEN_W'($urandom_range(9, 15));
            2, 3, 4: len = kscm_pkg::LEN_W'($urandom_range(5, 8));
            default: len = kscm_pkg::LEN_W'($urandom_range(1, 4));
        endcase
        for (int i = 0; i < 8 && i < int'(len); i++)
            bytes[8*i +: 8] = seq_byte();
        write_entry(slot, bytes, len, 8'($urandom));
    endtask

    // Type a stored sequence, or break away from it at a random key
    task automatic type_entry(input int slot, input bit stray);
        int          n;
        int          cut;
        logic [7:0]  b;
        n = (aim_len[slot] > 8) ? 8 : int'(aim_len[slot]);
        if (n == 0)
            n = 1;
        cut = stray ? $urandom_range(0, n - 1) : n;
        for (int i = 0; i < n; i++)
        begin
            b = aim_seq[slot][8*i +: 8];
            if (i == cut)
            begin
                press(b ^ 8'($urandom_range(1, 255)));
                return;
            end
            press(b);
        end
    endtask

    // Stop sending until every result is in and any last scan has finished
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_count(input logic [kscm_pkg::CNT_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid  <= 1'b0;
        live_count = value;
    endtask

    initial
    begin
        int phase;
        int pick;
        int active;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= kscm_pkg::CMD_WRITE;
        live_count = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No active entries after reset: every key is unrecognised at once
        press(8'h00);
        press(8'hFF);

        // Overlapping sequences; zero length, full length, overlong, junk past length
        write_entry(0, 64'h0, 4'd0, 8'h01);
        write_entry(1, 64'h41_5b_1b, 4'd3, 8'h10);
        write_entry(2, 64'h5b_1b, 4'd2, 8'h11);
        write_entry(3, 64'h1b, 4'd1, 8'h12);
        write_entry(4, '1, 4'd8, 8'hFF);
        write_entry(5, {8{8'h71}}, 4'd15, 8'h55);
        write_entry(6, 64'hFFFF_FFFF_FFFF_3231, 4'd2, 8'h20);
        set_count(7'd7);

        // first match is the long one; shorter exact ones further down lose
        press(8'h1b);
        press(8'h5b);
        press(8'h41);
        // zero-length slot must not catch a zero key
        press(8'h00);
        press(8'h31);
        press(8'h32);
        // eight keys into an entry longer than the buffer
        repeat (8) press(8'h71);

        // Fill the rest of the table before any wider scan
        for (int i = 7; i < TABLE_SLOTS; i++)
            write_random(i);

        // Random phases, each with its own active count
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (phase)
                0:       set_count(7'd127);
                1:       set_count(7'd64);
                2:       set_count(7'd0);
                3:       set_count(7'd1);
                4:       set_count(7'd65);
                default: set_count(($urandom_range(0, 4) == 0)
                                   ? kscm_pkg::CNT_W'($urandom_range(65, 127))
                                   : kscm_pkg::CNT_W'($urandom_range(1, 64)));
            endcase
            if (phase == 1)
                long_hold = 1'b1;
            active = (live_count > TABLE_SLOTS) ? TABLE_SLOTS : int'(live_count);
            repeat ($urandom_range(20, 50))
            begin
                if (items_sent < ITEM_TARGET)
                begin
                    if (items_sent >= CALM_FROM)
                        calm = 1'b1;
                    pick = $urandom_range(0, 19);
                    if (active == 0 || pick < 2)
                        press(8'($urandom));
                    else if (pick < 4)
                        write_random($urandom_range(0, TABLE_SLOTS - 1));
                    else if (pick < 5)
                        repeat ($urandom_range(2, 9)) press(8'h1b);
                    else if (pick < 8)
                        type_entry($urandom_range(0, active - 1), 1'b1);
                    else
                        type_entry($urandom_range(0, active - 1), 1'b0);
                end
            end
            phase++;
        end

        drain();
        if (fails == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// File: sim.f
sv/kscm_pkg.sv
sv/key_sequence_command_matcher.sv
dv/key_match_checker.sv
dv/tb.sv
